>>> src/grehp_pkg.sv
// grehp_pkg: types, constants and the byte classifier shared by the gre header parser
// no dependencies; compile first

package grehp_pkg;

    localparam int HDR_DEPTH   = 16;
    localparam int CNT_W       = $clog2(HDR_DEPTH) + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  FLAG_CSUM  = 8'h80;
    localparam logic [7:0]  FLAG_KEY   = 8'h20;
    localparam logic [7:0]  FLAG_SEQ   = 8'h10;
    localparam logic [7:0]  FLAG_ACK   = 8'h80;
    localparam logic [7:0]  VER_MASK   = 8'h07;
    localparam logic [15:0] PROTO_WLAN = 16'h8200;
    localparam logic [15:0] PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] PROTO_IPV6 = 16'h86DD;

    localparam logic [2:0] VER_GRE  = 3'd0;
    localparam logic [2:0] VER_PPTP = 3'd1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT_BASE,
        ST_SHORT_FULL,
        ST_BAD_VER
    } t_status;

    typedef enum logic [1:0] {
        RT_IP,
        RT_WLAN,
        RT_OTHER
    } t_route;

    // which captured field a header byte belongs to
    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_KEY,
        FLD_SEQ,
        FLD_ACK,
        FLD_PLEN,
        FLD_CALL
    } t_field;

    // per-packet summary, meaningful on the last word only
    typedef struct packed {
        t_status     status;
        logic [2:0]  gre_version;
        t_route      route;
        logic [15:0] next_protocol;
        logic [4:0]  header_length;
        logic [2:0]  fields_present;
    } t_summary;

    typedef struct packed {
        logic [7:0] data;
        t_field     tag;
        logic       last;
        t_summary   sum;
    } t_token;

    // field owning header byte idx (idx >= 4), given version and flag bytes
    function automatic t_field field_of(logic [7:0] flag, logic [7:0] verb,
                                        logic [3:0] idx);
        logic   c;
        logic   k;
        logic   s;
        logic   a;
        t_field f;
        c = |(flag & FLAG_CSUM);
        k = |(flag & FLAG_KEY);
        s = |(flag & FLAG_SEQ);
        a = |(verb & FLAG_ACK);
        f = FLD_NONE;
        if (verb[2:0] == VER_GRE) begin
            case (idx[3:2])
                2'd1: f = c ? FLD_NONE : (k ? FLD_KEY : (s ? FLD_SEQ : FLD_NONE));
                2'd2: begin
                    if (c) begin
                        f = k ? FLD_KEY : (s ? FLD_SEQ : FLD_NONE);
                    end else if (k) begin
                        f = s ? FLD_SEQ : FLD_NONE;
                    end
                end
                2'd3: f = (c && k && s) ? FLD_SEQ : FLD_NONE;
                default: f = FLD_NONE;
            endcase
        end else if (verb[2:0] == VER_PPTP) begin
            case (idx[3:2])
                2'd1: f = idx[1] ? FLD_CALL : FLD_PLEN;
                2'd2: f = s ? FLD_SEQ : (a ? FLD_ACK : FLD_NONE);
                2'd3: f = (s && a) ? FLD_ACK : FLD_NONE;
                default: f = FLD_NONE;
            endcase
        end
        return f;
    endfunction

endpackage

>>> src/grehp_in_if.sv
// grehp_in_if: byte channel into the gre header parser
// no dependencies

interface grehp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> src/grehp_out_if.sv
// grehp_out_if: result channel out of the gre header parser
// no dependencies

interface grehp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  gre_version;
    logic [1:0]  route;
    logic [15:0] next_protocol;
    logic [4:0]  header_length;
    logic [2:0]  fields_present;
    logic [31:0] key_value;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [15:0] call_id;
    logic [15:0] payload_length;

    modport source (output valid, output status, output gre_version, output route,
                    output next_protocol, output header_length, output fields_present,
                    output key_value, output sequence_number, output ack_number,
                    output call_id, output payload_length, input ready);
    modport sink (input valid, input status, input gre_version, input route,
                  input next_protocol, input header_length, input fields_present,
                  input key_value, input sequence_number, input ack_number,
                  input call_id, input payload_length, output ready);
endinterface

>>> src/grehp_front.sv
// grehp_front: counts header bytes, captures flags/version/protocol, tags each word
// depends on grehp_pkg and grehp_in_if

module grehp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    grehp_in_if.sink          i_in,
    output logic              o_tok_valid,
    output grehp_pkg::t_token o_tok,
    input  logic              i_tok_ready
);
    import grehp_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_flag, n_flag;
    logic [7:0]       r_ver, n_ver;
    logic [15:0]      r_proto, n_proto;

    logic       store;
    logic       accept;
    logic       c, k, s, a;
    logic [1:0] words;
    logic [2:0] ver;
    t_summary   sum;

    assign accept      = i_in.valid && i_tok_ready;
    assign i_in.ready  = i_tok_ready;
    assign o_tok_valid = i_in.valid;
    assign store       = (r_count < CNT_W'(HDR_DEPTH));

    always_comb begin
        n_count = r_count;
        n_flag  = r_flag;
        n_ver   = r_ver;
        n_proto = r_proto;
        if (store) begin
            n_count = r_count + 1'b1;
            case (r_count)
                CNT_W'(0): n_flag  = i_in.data_byte;
                CNT_W'(1): n_ver   = i_in.data_byte;
                CNT_W'(2): n_proto = {i_in.data_byte, r_proto[7:0]};
                CNT_W'(3): n_proto = {r_proto[15:8], i_in.data_byte};
                default: ;
            endcase
        end
    end

    // summary of the packet as it stands after this byte
    always_comb begin
        ver = n_ver[2:0] & VER_MASK[2:0];
        c   = |(n_flag & FLAG_CSUM);
        k   = |(n_flag & FLAG_KEY);
        s   = |(n_flag & FLAG_SEQ);
        a   = |(n_ver & FLAG_ACK);
        sum = '0;
        sum.status        = ST_OK;
        sum.gre_version   = ver;
        sum.next_protocol = n_proto;
        words = 2'd0;
        if (n_proto == PROTO_WLAN) begin
            sum.route = RT_WLAN;
        end else if (n_proto == PROTO_IPV4 || n_proto == PROTO_IPV6) begin
            sum.route = RT_IP;
        end else begin
            sum.route = RT_OTHER;
        end
        if (n_count < CNT_W'(4)) begin
            sum.status = ST_SHORT_BASE;
        end else if (ver == VER_GRE) begin
            words = {1'b0, c} + {1'b0, k} + {1'b0, s};
            sum.header_length  = 5'd4 + {1'b0, words, 2'b00};
            sum.fields_present = {1'b0, s, k};
            if (n_count < sum.header_length) begin
                sum.status = ST_SHORT_FULL;
            end
        end else if (ver == VER_PPTP) begin
            if (n_count < CNT_W'(8)) begin
                sum.status = ST_SHORT_BASE;
            end else begin
                words = {1'b0, s} + {1'b0, a};
                sum.header_length  = 5'd8 + {1'b0, words, 2'b00};
                sum.fields_present = {a, s, 1'b0};
                if (n_count < sum.header_length) begin
                    sum.status = ST_SHORT_FULL;
                end
            end
        end else begin
            sum.status = ST_BAD_VER;
        end
    end

    always_comb begin
        o_tok.data = i_in.data_byte;
        o_tok.last = i_in.last_byte;
        o_tok.tag  = (store && r_count >= CNT_W'(4)) ?
                     field_of(r_flag, r_ver, r_count[CNT_W-2:0]) : FLD_NONE;
        o_tok.sum  = sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flag  <= '0;
            r_ver   <= '0;
            r_proto <= '0;
        end else if (accept) begin
            if (i_in.last_byte) begin
                r_count <= '0;
                r_flag  <= '0;
                r_ver   <= '0;
                r_proto <= '0;
            end else begin
                r_count <= n_count;
                r_flag  <= n_flag;
                r_ver   <= n_ver;
                r_proto <= n_proto;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HDR_DEPTH))
        else $error("byte count beyond header depth");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.last_byte) |=> (r_count == '0 && r_ver == '0))
        else $error("parser not cleared after last word");

endmodule

>>> src/grehp_queue.sv
// grehp_queue: short token queue between the classifying front and the capture back
// depends on grehp_pkg

module grehp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  grehp_pkg::t_token i_tok,
    output logic              o_ready,
    output logic              o_valid,
    output grehp_pkg::t_token o_tok,
    input  logic              i_pop
);
    import grehp_pkg::*;

    t_token                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_ready = (r_count != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    // depth is a power of two, so pointers wrap by overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

endmodule

>>> src/grehp_back.sv
// grehp_back: assembles tagged words into key/sequence/ack/pptp fields, registers the result
// depends on grehp_pkg and grehp_out_if

module grehp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    input  grehp_pkg::t_token i_tok,
    output logic              o_tok_pop,
    grehp_out_if.source       o_out
);
    import grehp_pkg::*;

    logic [31:0] r_key, n_key;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ack, n_ack;
    logic [15:0] r_call, n_call;
    logic [15:0] r_plen, n_plen;

    logic        r_out_valid;
    t_summary    r_out_sum;
    logic [31:0] r_out_key;
    logic [31:0] r_out_seq;
    logic [31:0] r_out_ack;
    logic [15:0] r_out_call;
    logic [15:0] r_out_plen;

    logic     pop;
    logic     ok;
    t_summary out_sum;

    // only the last word needs room in the output register
    assign pop       = i_tok_valid && (!i_tok.last || !r_out_valid || o_out.ready);
    assign o_tok_pop = pop;
    assign ok        = (i_tok.sum.status == ST_OK);

    always_comb begin
        n_key  = r_key;
        n_seq  = r_seq;
        n_ack  = r_ack;
        n_call = r_call;
        n_plen = r_plen;
        case (i_tok.tag)
            FLD_KEY:  n_key  = {r_key[23:0], i_tok.data};
            FLD_SEQ:  n_seq  = {r_seq[23:0], i_tok.data};
            FLD_ACK:  n_ack  = {r_ack[23:0], i_tok.data};
            FLD_PLEN: n_plen = {r_plen[7:0], i_tok.data};
            FLD_CALL: n_call = {r_call[7:0], i_tok.data};
            default: ;
        endcase
    end

    // error results keep only status and version
    always_comb begin
        out_sum = i_tok.sum;
        if (!ok) begin
            out_sum.route          = RT_IP;
            out_sum.next_protocol  = '0;
            out_sum.header_length  = '0;
            out_sum.fields_present = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_seq  <= '0;
            r_ack  <= '0;
            r_call <= '0;
            r_plen <= '0;
        end else if (pop) begin
            if (i_tok.last) begin
                r_key  <= '0;
                r_seq  <= '0;
                r_ack  <= '0;
                r_call <= '0;
                r_plen <= '0;
            end else begin
                r_key  <= n_key;
                r_seq  <= n_seq;
                r_ack  <= n_ack;
                r_call <= n_call;
                r_plen <= n_plen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop && i_tok.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_tok.last) begin
            r_out_sum  <= out_sum;
            r_out_key  <= ok ? n_key : '0;
            r_out_seq  <= ok ? n_seq : '0;
            r_out_ack  <= ok ? n_ack : '0;
            r_out_call <= ok ? n_call : '0;
            r_out_plen <= ok ? n_plen : '0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out_sum.status;
    assign o_out.gre_version     = r_out_sum.gre_version;
    assign o_out.route           = r_out_sum.route;
    assign o_out.next_protocol   = r_out_sum.next_protocol;
    assign o_out.header_length   = r_out_sum.header_length;
    assign o_out.fields_present  = r_out_sum.fields_present;
    assign o_out.key_value       = r_out_key;
    assign o_out.sequence_number = r_out_seq;
    assign o_out.ack_number      = r_out_ack;
    assign o_out.call_id         = r_out_call;
    assign o_out.payload_length  = r_out_plen;

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_tok.last) |=> r_out_valid)
        else $error("last word popped without a result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(pop && i_tok.last))
        else $error("pending result overwritten");

endmodule

>>> src/gre_header_parser.sv
// gre_header_parser: top level of the gre / pptp enhanced gre header parser
// depends on grehp_pkg, grehp_in_if, grehp_out_if, grehp_front, grehp_queue, grehp_back
//
// usage:
//   i_in carries the packet one word (byte) per cycle from its first byte, with
//   last_byte marking the final one. o_out gives exactly one result per packet:
//   status, version, route, protocol, header length and the captured key,
//   sequence, acknowledgement and pptp call id / payload length.
//   throughput is one word per cycle, back to back across packets, while o_out
//   keeps taking results; the front classifies each word in the cycle it is
//   accepted and pushes it into a two-entry queue, the back drains one word per cycle.
//   with the queue empty, the last word is first written into the queue, then
//   popped into the output register, which then holds the valid result.
//   when o_out stalls, the result is held in the output register; words keep
//   flowing until a second last word reaches the back, then the queue fills and
//   i_in.ready drops.
//   reset clears the byte counter, the captured header bytes, the queue and
//   the output valid; the block is ready in the first cycle after reset.

module gre_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    grehp_in_if.sink     i_in,
    grehp_out_if.source  o_out
);
    import grehp_pkg::*;

    logic   front_valid;
    t_token front_tok;
    logic   q_ready;
    logic   q_valid;
    t_token q_tok;
    logic   q_pop;

    grehp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_tok_valid (front_valid),
        .o_tok       (front_tok),
        .i_tok_ready (q_ready)
    );

    grehp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_tok   (front_tok),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_tok   (q_tok),
        .i_pop   (q_pop)
    );

    grehp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (q_pop),
        .o_out       (o_out)
    );

endmodule

>>> bench/gre_result_checker.sv
// gre_result_checker: watches both channels of the gre header parser, predicts one
// result per packet from the accepted words and compares it with what the block gives
// depends on grehp_pkg, grehp_in_if, grehp_out_if

module gre_result_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    grehp_in_if   i_byte_ch,
    grehp_out_if  i_result_ch,
    output int    o_fail_count,
    output int    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import grehp_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_status     status;
        logic [2:0]  gre_version;
        t_route      route;
        logic [15:0] next_protocol;
        logic [4:0]  header_length;
        logic [2:0]  fields_present;
        logic [31:0] key_value;
        logic [31:0] sequence_number;
        logic [31:0] ack_number;
        logic [15:0] call_id;
        logic [15:0] payload_length;
    } t_gre_result;

    // captured header of the packet in flight
    logic [4:0]  seen_cnt;
    logic [7:0]  flag_b;
    logic [7:0]  ver_b;
    logic [15:0] proto_w;
    logic [7:0]  hdr_q [HDR_DEPTH];

    t_gre_result pending_results [$];
    int          fails;

    function automatic void clear_capture();
        seen_cnt = '0;
        flag_b   = '0;
        ver_b    = '0;
        proto_w  = '0;
        for (int i = 0; i < HDR_DEPTH; i++) begin
            hdr_q[i] = '0;
        end
    endfunction

    function automatic logic [31:0] be_word(int off);
        return {hdr_q[off], hdr_q[off + 1], hdr_q[off + 2], hdr_q[off + 3]};
    endfunction

    function automatic t_gre_result decode_header();
        t_gre_result r;
        t_status     st;
        t_route      rt;
        logic [2:0]  ver;
        logic [2:0]  pres;
        logic [31:0] key;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] call;
        logic [15:0] plen;
        int          off;
        int          hl;
        ver  = ver_b[2:0];
        st   = ST_OK;
        pres = '0;
        key  = '0;
        seq  = '0;
        ack  = '0;
        call = '0;
        plen = '0;
        hl   = 0;
        if (seen_cnt < 4) begin
            st = ST_SHORT_BASE;
        end else if (ver == VER_GRE) begin
            off = 4;
            if (|(flag_b & FLAG_CSUM)) off += 4;
            if (|(flag_b & FLAG_KEY)) begin
                pres[0] = 1'b1;
                key = be_word(off);
                off += 4;
            end
            if (|(flag_b & FLAG_SEQ)) begin
                pres[1] = 1'b1;
                seq = be_word(off);
                off += 4;
            end
            hl = off;
            if (seen_cnt < hl) st = ST_SHORT_FULL;
        end else if (ver == VER_PPTP) begin
            if (seen_cnt < 8) begin
                st = ST_SHORT_BASE;
            end else begin
                off  = 8;
                plen = {hdr_q[4], hdr_q[5]};
                call = {hdr_q[6], hdr_q[7]};
                if (|(flag_b & FLAG_SEQ)) begin
                    pres[1] = 1'b1;
                    seq = be_word(off);
                    off += 4;
                end
                // ack flag sits in the version byte for pptp
                if (|(ver_b & FLAG_ACK)) begin
                    pres[2] = 1'b1;
                    ack = be_word(off);
                    off += 4;
                end
                hl = off;
                if (seen_cnt < hl) st = ST_SHORT_FULL;
            end
        end else begin
            st = ST_BAD_VER;
        end

        if (proto_w == PROTO_WLAN) begin
            rt = RT_WLAN;
        end else if (proto_w == PROTO_IPV4 || proto_w == PROTO_IPV6) begin
            rt = RT_IP;
        end else begin
            rt = RT_OTHER;
        end

        r = '0;
        r.status      = st;
        r.gre_version = ver;
        // error results carry only status and version
        if (st == ST_OK) begin
            r.route           = rt;
            r.next_protocol   = proto_w;
            r.header_length   = 5'(hl);
            r.fields_present  = pres;
            r.key_value       = key;
            r.sequence_number = seq;
            r.ack_number      = ack;
            r.call_id         = call;
            r.payload_length  = plen;
        end
        return r;
    endfunction

    function automatic string fmt_result(t_gre_result r);
        return $sformatf({"st=%0d ver=%0d rt=%0d proto=%h hlen=%0d pres=%b key=%h seq=%h",
                          " ack=%h call=%h plen=%h"},
                         r.status, r.gre_version, r.route, r.next_protocol,
                         r.header_length, r.fields_present, r.key_value,
                         r.sequence_number, r.ack_number, r.call_id, r.payload_length);
    endfunction

    always @(posedge i_clk) begin
        t_gre_result want;
        t_gre_result got;
        if (!i_rst_n) begin
            clear_capture();
            pending_results.delete();
            fails = 0;
        end else begin
            if (i_byte_ch.valid === 1'b1 && i_byte_ch.ready === 1'b1) begin
                if (seen_cnt < HDR_DEPTH) begin
                    hdr_q[seen_cnt[3:0]] = i_byte_ch.data_byte;
                    case (seen_cnt)
                        5'd0: flag_b = i_byte_ch.data_byte;
                        5'd1: ver_b = i_byte_ch.data_byte;
                        5'd2: proto_w[15:8] = i_byte_ch.data_byte;
                        5'd3: proto_w[7:0] = i_byte_ch.data_byte;
                        default: ;
                    endcase
                    seen_cnt = seen_cnt + 5'd1;
                end
                if (i_byte_ch.last_byte === 1'b1) begin
                    pending_results.push_back(decode_header());
                    clear_capture();
                end
            end

            if (i_result_ch.valid === 1'b1 && i_result_ch.ready === 1'b1) begin
                got.status          = t_status'(i_result_ch.status);
                got.gre_version     = i_result_ch.gre_version;
                got.route           = t_route'(i_result_ch.route);
                got.next_protocol   = i_result_ch.next_protocol;
                got.header_length   = i_result_ch.header_length;
                got.fields_present  = i_result_ch.fields_present;
                got.key_value       = i_result_ch.key_value;
                got.sequence_number = i_result_ch.sequence_number;
                got.ack_number      = i_result_ch.ack_number;
                got.call_id         = i_result_ch.call_id;
                got.payload_length  = i_result_ch.payload_length;
                if (pending_results.size() == 0) begin
                    if (fails < REPORT_MAX) begin
                        $display("%0t unexpected result: %s", $realtime, fmt_result(got));
                    end
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (fails < REPORT_MAX) begin
                            $display("%0t result mismatch\n  expected: %s\n  actual:   %s",
                                     $realtime, fmt_result(want), fmt_result(got));
                        end
                        fails++;
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= pending_results.size();
    end

endmodule

>>> bench/tb_gre_header_parser.sv
// tb_gre_header_parser: drives gre / pptp packets into the header parser with random
// gaps and output stalls, and gives the verdict from the checker's failure count
// depends on grehp_pkg, grehp_in_if, grehp_out_if, gre_header_parser, gre_result_checker

module tb_gre_header_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import grehp_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int RANDOM_BYTES = 300;
    localparam int SETTLE_CYCLES = 10;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES
    } t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   no_stall;
    int   bytes_sent;
    int   fail_count;
    int   outstanding;

    grehp_in_if  in_ch ();
    grehp_out_if out_ch ();

    gre_header_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    gre_result_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_ch     (in_ch),
        .i_result_ch   (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_stall) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic put_word(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.last_byte <= l;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_gre(input logic [7:0] flag, input logic [7:0] verb,
                            input logic [15:0] proto, input int len, input t_fill fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (i)
                0: b = flag;
                1: b = verb;
                2: b = proto[15:8];
                3: b = proto[7:0];
                default: begin
                    case (fill)
                        FILL_ZEROS: b = 8'h00;
                        FILL_ONES:  b = 8'hFF;
                        default:    b = 8'($urandom);
                    endcase
                end
            endcase
            put_word(b, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic random_packet();
        logic [2:0]  ver;
        logic [7:0]  flag;
        logic [7:0]  verb;
        logic [15:0] proto;
        int          hlen;
        int          len;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 45) ver = VER_GRE;
        else if (r < 85) ver = VER_PPTP;
        else ver = 3'($urandom_range(0, 7));
        flag = 8'($urandom);
        verb = (8'($urandom) & ~VER_MASK) | {5'd0, ver};
        case ($urandom_range(0, 4))
            0: proto = PROTO_IPV4;
            1: proto = PROTO_IPV6;
            2: proto = PROTO_WLAN;
            default: proto = 16'($urandom);
        endcase
        if (ver == VER_GRE) begin
            hlen = 4 + 4 * (int'(|(flag & FLAG_CSUM)) + int'(|(flag & FLAG_KEY))
                            + int'(|(flag & FLAG_SEQ)));
        end else if (ver == VER_PPTP) begin
            hlen = 8 + 4 * (int'(|(flag & FLAG_SEQ)) + int'(|(verb & FLAG_ACK)));
        end else begin
            hlen = 4;
        end
        r = $urandom_range(0, 99);
        if (r < 70) len = hlen + $urandom_range(0, 8);
        else if (r < 85) len = $urandom_range(1, hlen - 1);
        else len = $urandom_range(17, 40);
        send_gre(flag, verb, proto, len, FILL_RANDOM);
    endtask

    // result side: runs of ready broken by stalls of random length
    initial begin
        int run;
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            run = $urandom_range(1, 12);
            out_ch.ready <= 1'b1;
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    initial begin
        int n;
        n = 0;
        while (n < LIMIT_CYCLES) begin
            @(posedge i_clk);
            n++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.last_byte <= 1'b0;
        no_stall   = 1'b0;
        bytes_sent = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // too short for any base header, bad version hidden behind short length
        send_gre(8'hFF, 8'hFF, 16'hFFFF, 1, FILL_ONES);
        send_gre(8'h00, 8'h01, 16'h0000, 2, FILL_ZEROS);
        send_gre(8'h00, 8'h07, 16'h0800, 3, FILL_RANDOM);
        // plain gre, each flag combination
        send_gre(8'h00, 8'h00, 16'h0000, 4, FILL_ZEROS);
        send_gre(8'h00, 8'h00, 16'h0800, 4, FILL_ZEROS);
        send_gre(8'h20, 8'h00, 16'h86DD, 8, FILL_RANDOM);
        send_gre(8'h10, 8'h40, 16'h8200, 8, FILL_RANDOM);
        send_gre(8'h80, 8'h00, 16'h0801, 8, FILL_RANDOM);
        send_gre(8'hA0, 8'h00, 16'h0800, 12, FILL_RANDOM);
        send_gre(8'h90, 8'h00, 16'h0800, 12, FILL_RANDOM);
        send_gre(8'h30, 8'h00, 16'h8200, 12, FILL_RANDOM);
        send_gre(8'hB0, 8'h00, 16'h86DD, 16, FILL_ONES);
        send_gre(8'hFF, 8'hF8, 16'hFFFF, 16, FILL_ONES);
        send_gre(8'hB0, 8'h00, 16'h86DD, 15, FILL_RANDOM);
        // pptp: short base, bare, seq, ack, both, short full
        send_gre(8'h10, 8'h81, 16'h880B, 7, FILL_RANDOM);
        send_gre(8'hEF, 8'h01, 16'h8200, 8, FILL_ONES);
        send_gre(8'h10, 8'h01, 16'h0800, 12, FILL_RANDOM);
        send_gre(8'h00, 8'h81, 16'h0800, 12, FILL_RANDOM);
        send_gre(8'h10, 8'h81, 16'h880B, 16, FILL_RANDOM);
        send_gre(8'h10, 8'h81, 16'h0800, 13, FILL_RANDOM);
        // every bad version
        for (int v = 2; v < 8; v++) begin
            send_gre(8'hB0, 8'(v), 16'h0800, 4 + v, FILL_RANDOM);
        end
        // long packets, tail beyond the captured header
        send_gre(8'hB0, 8'h00, 16'h0800, 30, FILL_RANDOM);
        send_gre(8'h10, 8'h81, 16'h86DD, 40, FILL_RANDOM);

        in_ch.valid <= 1'b0;
        wait_drained();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 19) == 0) begin
                in_ch.valid <= 1'b0;
                wait_drained();
            end
            no_stall = ($urandom_range(0, 6) == 0);
            random_packet();
        end
        no_stall = 1'b0;
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
